// ===== rtl/slpd_pkg.sv =====
package slpd_pkg;

  // Packet length in bytes: up to 65535 words * 4 + 8 = 262148
  localparam int LEN_W = 19;

  localparam logic [7:0] HEAD_RESET = 8'hAA;
  localparam logic [7:0] TAIL_RESET = 8'hCC;

  // Header byte positions and length rule
  localparam logic [LEN_W-1:0] IDX_COUNT_HI = LEN_W'(4);
  localparam logic [LEN_W-1:0] IDX_COUNT_LO = LEN_W'(5);
  localparam logic [LEN_W-1:0] IDX_LAST_MIN = LEN_W'(6);
  localparam logic [LEN_W-1:0] LEN_BASE     = LEN_W'(8);

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_HEAD = 1'b0,
    CFG_TAIL = 1'b1
  } cfg_idx_e;

  // Framer result for one item
  typedef struct packed {
    logic       hit;
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       tail_good;
  } res_t;

  // Framer status
  typedef struct packed {
    logic             in_packet;
    logic [LEN_W-1:0] byte_index;
  } status_t;

endpackage

// ===== rtl/slpd_framer.sv =====
module slpd_framer
  import slpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] rx_byte,
  input  logic [7:0] head_value,
  input  logic [7:0] tail_value,
  output res_t       res,
  output status_t    status
);

  logic             phase;
  logic [LEN_W-1:0] byte_index;
  logic [LEN_W-1:0] total_length;
  logic [7:0]       count_high;
  logic             prior_was_tail;

  logic             is_tail;
  logic [LEN_W-1:0] index_plus;
  logic [LEN_W-1:0] length_next;

  assign is_tail     = (rx_byte == tail_value);
  assign index_plus  = byte_index + LEN_W'(1);
  assign length_next = {1'b0, count_high, rx_byte, 2'b00} + LEN_BASE;

  // Decode the current item
  always_comb begin
    res.data      = rx_byte;
    res.first     = 1'b0;
    res.last      = 1'b0;
    res.tail_good = 1'b0;
    if (!phase) begin
      res.hit   = (rx_byte == head_value);
      res.first = 1'b1;
    end else begin
      res.hit       = 1'b1;
      res.last      = (byte_index >= IDX_LAST_MIN) && (index_plus >= total_length);
      res.tail_good = res.last && prior_was_tail && is_tail;
    end
  end

  assign status.in_packet  = phase;
  assign status.byte_index = byte_index;

  // Advance the framing state on each item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= 1'b0;
      byte_index     <= '0;
      total_length   <= '0;
      count_high     <= '0;
      prior_was_tail <= 1'b0;
    end else if (step) begin
      if (!phase) begin
        if (res.hit) begin
          phase          <= 1'b1;
          byte_index     <= LEN_W'(1);
          total_length   <= '0;
          count_high     <= '0;
          prior_was_tail <= is_tail;
        end
      end else begin
        if (byte_index == IDX_COUNT_HI) begin
          count_high <= rx_byte;
        end else if (byte_index == IDX_COUNT_LO) begin
          total_length <= length_next;
        end
        if (res.last) begin
          phase          <= 1'b0;
          byte_index     <= '0;
          prior_was_tail <= 1'b0;
        end else begin
          byte_index     <= index_plus;
          prior_was_tail <= is_tail;
        end
      end
    end
  end

endmodule

// ===== rtl/sync_length_packet_deframer.sv =====
// Byte-stream packet deframer. Bytes outside a packet are dropped until one
// equals head_value; that byte and the rest of the packet pass through. Header
// bytes 4 and 5 are a big-endian word count, and the packet is count*4+8 bytes
// long. tuser[0] marks the head byte, tlast the final byte, and tuser[1] on the
// final byte says that the last two bytes both equal tail_value. A bad tail
// does not resync: the packet ends at its stated length and hunting resumes.
// One item is taken per cycle while the result is not stalled; an item goes
// through an input register and then a result register before its result is
// offered. Only a stalled result holds off the input.
module sync_length_packet_deframer
  import slpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // input stream
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] rx_byte
  // output stream
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] packet_byte
  output logic       m_tlast,   // last_of_packet
  output logic [1:0] m_tuser,   // [0] first_of_packet, [1] tail_good
  // configuration
  input  logic       cfg_we,
  input  cfg_idx_e   cfg_index,
  input  logic [7:0] cfg_data
);

  logic [7:0] head_reg;
  logic [7:0] tail_reg;
  logic       in_valid;
  logic [7:0] in_data;
  logic       advance;
  logic       step;
  res_t       res;
  status_t    status;

  assign advance    = !m_tvalid || m_tready;
  assign s_tready   = !in_valid || advance;
  assign step       = in_valid && advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head_reg <= HEAD_RESET;
      tail_reg <= TAIL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEAD: head_reg <= cfg_data;
        CFG_TAIL: tail_reg <= cfg_data;
        default:  head_reg <= head_reg;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_data <= s_tdata;
    end
  end

  slpd_framer u_framer (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .rx_byte    (in_data),
    .head_value (head_reg),
    .tail_value (tail_reg),
    .res        (res),
    .status     (status)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= step && res.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata    <= res.data;
      m_tlast    <= res.last;
      m_tuser[0] <= res.first;
      m_tuser[1] <= res.tail_good;
    end
  end

  // A packet is at least eight bytes: head and final byte never coincide
  a_first_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tlast && m_tuser[0]))
    else $error("head byte marked as final byte");

  // Tail status only on the final byte
  a_tail_on_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tlast)
    else $error("tail_good outside final byte");

  // Hunting leaves the byte counter cleared
  a_hunt_index: assert property (@(posedge clk) disable iff (rst)
    !status.in_packet |-> status.byte_index == '0)
    else $error("byte index nonzero while hunting");

  // A final byte returns the framer to hunting
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    step && res.hit && res.last |=> !status.in_packet)
    else $error("framer stayed in packet after final byte");

endmodule
